[design/text_console_cursor_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// Text console cursor engine: assertion macros
// Shared assertion forms, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Field widths, codes, shared types and the ring row helper.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [7:0] TEXT_COLOR_RST = 8'd7;
  localparam logic [7:0] BLANK_CODE_RST = 8'd0;

  typedef enum logic [0:0] {
    OP_PUT   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CMD_CELL = 1'b0,
    CMD_FILL = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_TEXT_COLOR = 1'b0,
    REG_BLANK_CODE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    JOB_IDLE,
    JOB_CHAR,
    JOB_CLEAR
  } job_e;

  typedef struct packed {
    logic [7:0] text_color;
    logic [7:0] blank_code;
  } cfg_t;

  typedef struct packed {
    cmd_e              command;
    logic [ROW_W-1:0]  phys_row;
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] cell_entry;
    logic [ROW_W-1:0]  top_row;
    logic              last;
  } result_t;

  typedef struct packed {
    logic             job_idle;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] top_row;
  } status_t;

  // Physical row of a logical row: the sum stays below twice the row count,
  // so one compare and subtract folds it back into range.
  function automatic logic [ROW_W-1:0] ring_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] row,
                                                input int               rows);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (ROW_W+1)'(rows)) begin
      sum = sum - (ROW_W+1)'(rows);
    end
    return sum[ROW_W-1:0];
  endfunction

endpackage

[design/tcce_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Text console cursor engine configuration registers
// APB-style register file holding the attribute byte and the blank code.
// ----------------------------------------------------------------------------
module tcce_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tcce_pkg::cfg_t    cfg_o
);

  logic       wr_en;
  logic [7:0] text_color_q, text_color_d;
  logic [7:0] blank_code_q, blank_code_d;
  tcce_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = tcce_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    text_color_d = text_color_q;
    blank_code_d = blank_code_q;
    if (wr_en) begin
      unique case (idx)
        tcce_pkg::REG_TEXT_COLOR: text_color_d = pwdata[7:0];
        tcce_pkg::REG_BLANK_CODE: blank_code_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tcce_pkg::REG_TEXT_COLOR: prdata = {24'd0, text_color_q};
      tcce_pkg::REG_BLANK_CODE: prdata = {24'd0, blank_code_q};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcce_pkg::TEXT_COLOR_RST;
      blank_code_q <= tcce_pkg::BLANK_CODE_RST;
    end else begin
      text_color_q <= text_color_d;
      blank_code_q <= blank_code_d;
    end
  end

  assign cfg_o.text_color = text_color_q;
  assign cfg_o.blank_code = blank_code_q;

endmodule

[design/tcce_engine.sv]
// ----------------------------------------------------------------------------
// Text console cursor engine core
// Cursor and ring state, follow-up job sequencer and the result register.
// ----------------------------------------------------------------------------
module tcce_engine #(
  parameter int Columns = tcce_pkg::COLUMNS_DEF,
  parameter int Rows    = tcce_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcce_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tcce_pkg::op_e                 in_op_i,
  input  logic [tcce_pkg::CHAR_W-1:0]   in_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tcce_pkg::result_t             out_o,
  output tcce_pkg::status_t             status_o
);

  localparam int RW = tcce_pkg::ROW_W;
  localparam int CW = tcce_pkg::COL_W;
  localparam logic [RW-1:0] LastRow = RW'(Rows - 1);
  localparam logic [CW-1:0] LastCol = CW'(Columns - 1);

  logic [RW-1:0]      cursor_row_q, cursor_row_d;
  logic [CW-1:0]      cursor_col_q, cursor_col_d;
  logic               scroll_pending_q, scroll_pending_d;
  logic [RW-1:0]      top_q, top_d;
  tcce_pkg::job_e     job_q, job_d;
  logic [RW-1:0]      clr_row_q, clr_row_d;
  tcce_pkg::result_t  pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  tcce_pkg::result_t  out_q, out_d;

  logic               load_ok;
  logic               in_fire;
  logic [RW-1:0]      top_inc;
  logic [RW-1:0]      eff_top;
  logic [15:0]        blank_cell;
  tcce_pkg::result_t  char_res;
  tcce_pkg::result_t  fill_res;

  assign load_ok    = !out_valid_q || out_ready_i;
  assign in_ready_o = load_ok && (job_q == tcce_pkg::JOB_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign top_inc    = (top_q == LastRow) ? '0 : top_q + RW'(1);
  assign eff_top    = scroll_pending_q ? top_inc : top_q;
  assign blank_cell = {cfg_i.text_color, cfg_i.blank_code};

  always_comb begin
    char_res.command    = tcce_pkg::CMD_CELL;
    char_res.phys_row   = tcce_pkg::ring_row(eff_top, cursor_row_q, Rows);
    char_res.column     = cursor_col_q;
    char_res.cell_entry = {cfg_i.text_color, in_char_i};
    char_res.top_row    = eff_top;
    char_res.last       = 1'b1;

    // After the pointer advances, the new bottom line is the old top row.
    fill_res.command    = tcce_pkg::CMD_FILL;
    fill_res.phys_row   = top_q;
    fill_res.column     = '0;
    fill_res.cell_entry = blank_cell;
    fill_res.top_row    = eff_top;
    fill_res.last       = 1'b0;
  end

  always_comb begin
    cursor_row_d     = cursor_row_q;
    cursor_col_d     = cursor_col_q;
    scroll_pending_d = scroll_pending_q;
    top_d            = top_q;
    job_d            = job_q;
    clr_row_d        = clr_row_q;
    pend_d           = pend_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q && !out_ready_i;

    unique case (job_q)
      tcce_pkg::JOB_CHAR: begin
        if (load_ok) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          job_d       = tcce_pkg::JOB_IDLE;
        end
      end
      tcce_pkg::JOB_CLEAR: begin
        if (load_ok) begin
          out_d.command    = tcce_pkg::CMD_FILL;
          out_d.phys_row   = clr_row_q;
          out_d.column     = '0;
          out_d.cell_entry = blank_cell;
          out_d.top_row    = '0;
          out_d.last       = (clr_row_q == LastRow);
          out_valid_d      = 1'b1;
          if (clr_row_q == LastRow) begin
            job_d = tcce_pkg::JOB_IDLE;
          end else begin
            clr_row_d = clr_row_q + RW'(1);
          end
        end
      end
      default: begin
        if (in_fire) begin
          if (in_op_i == tcce_pkg::OP_CLEAR) begin
            cursor_row_d     = '0;
            cursor_col_d     = '0;
            scroll_pending_d = 1'b0;
            top_d            = '0;
            out_d.command    = tcce_pkg::CMD_FILL;
            out_d.phys_row   = '0;
            out_d.column     = '0;
            out_d.cell_entry = blank_cell;
            out_d.top_row    = '0;
            out_d.last       = 1'b0;
            out_valid_d      = 1'b1;
            clr_row_d        = RW'(1);
            job_d            = tcce_pkg::JOB_CLEAR;
          end else if (in_char_i == tcce_pkg::NEWLINE_CODE) begin
            cursor_col_d = '0;
            if (cursor_row_q == LastRow) begin
              scroll_pending_d = 1'b1;
            end else begin
              cursor_row_d = cursor_row_q + RW'(1);
            end
          end else begin
            top_d            = eff_top;
            scroll_pending_d = 1'b0;
            out_valid_d      = 1'b1;
            if (scroll_pending_q) begin
              out_d  = fill_res;
              pend_d = char_res;
              job_d  = tcce_pkg::JOB_CHAR;
            end else begin
              out_d = char_res;
            end
            if (cursor_col_q == LastCol) begin
              cursor_col_d = '0;
              if (cursor_row_q == LastRow) begin
                scroll_pending_d = 1'b1;
              end else begin
                cursor_row_d = cursor_row_q + RW'(1);
              end
            end else begin
              cursor_col_d = cursor_col_q + CW'(1);
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_row_q     <= '0;
      cursor_col_q     <= '0;
      scroll_pending_q <= 1'b0;
      top_q            <= '0;
      job_q            <= tcce_pkg::JOB_IDLE;
      clr_row_q        <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      cursor_row_q     <= cursor_row_d;
      cursor_col_q     <= cursor_col_d;
      scroll_pending_q <= scroll_pending_d;
      top_q            <= top_d;
      job_q            <= job_d;
      clr_row_q        <= clr_row_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_o               = out_q;
  assign status_o.job_idle   = (job_q == tcce_pkg::JOB_IDLE);
  assign status_o.cursor_row = cursor_row_q;
  assign status_o.cursor_col = cursor_col_q;
  assign status_o.top_row    = top_q;

endmodule

[design/text_console_cursor_engine_top.sv]
// A request's first result, if any, is registered by the edge that takes the request.
// Plain characters and newlines start no follow-up job; a character that first scrolls
// sends a fill, then its cell; a clear fills each row in turn via the row fill counter.
// Reset (rst_ni low, asynchronous) homes the cursor, zeroes the ring pointer,
// drops any output and restores the attribute to 7 and the blank code to 0.
// ----------------------------------------------------------------------------
// Text console cursor engine top level
// Streams characters and clear requests into cell write commands for a
// ring-scrolled text-cell memory.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_top_defines.svh"

module text_console_cursor_engine_top #(
  parameter int Columns = tcce_pkg::COLUMNS_DEF,
  parameter int Rows    = tcce_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  logic        s_axis_tuser,  // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] phys_row, [11:5] column, [27:12] cell_entry, [32:28] top_row, [39:33] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] command
  output logic        m_axis_tlast
);

  tcce_pkg::cfg_t    cfg;
  tcce_pkg::result_t res;
  tcce_pkg::status_t status;

  tcce_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcce_engine #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (tcce_pkg::op_e'(s_axis_tuser)),
    .in_char_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .status_o    (status)
  );

  assign m_axis_tdata = {7'd0, res.top_row, res.cell_entry, res.column, res.phys_row};
  assign m_axis_tuser = res.command;
  assign m_axis_tlast = res.last;

  `TCCE_ASSERT_NOW(a_row_in_range, 1'b1, int'(status.cursor_row) < Rows,
    "cursor row out of range")
  `TCCE_ASSERT_NOW(a_col_in_range, 1'b1, int'(status.cursor_col) < Columns,
    "cursor column out of range")
  `TCCE_ASSERT_NOW(a_top_in_range, 1'b1, int'(status.top_row) < Rows,
    "top row pointer out of range")
  `TCCE_ASSERT_NOW(a_ready_only_idle, s_axis_tready, status.job_idle,
    "input taken while a follow-up job is running")
  `TCCE_ASSERT_NEXT(a_clear_starts_row0,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == tcce_pkg::OP_CLEAR,
    m_axis_tvalid && m_axis_tuser == tcce_pkg::CMD_FILL && m_axis_tdata[4:0] == 5'd0,
    "clear did not start with a fill of row zero")

endmodule
